// ----- rtl/crcr_pkg.sv -----
// Shared definitions for the reflected CRC-16 block.
// Field widths, register indexes and the configuration bundle.
// No dependencies.
package crcr_pkg;

	localparam int CRC_W     = 16;
	localparam int BYTE_W    = 8;
	localparam int SHIFT_W   = 5;
	localparam int MaxShifts = 16;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 3;

	localparam logic [CRC_W-1:0]   POLY_RESET   = 16'hA001;
	localparam logic [SHIFT_W-1:0] SHIFTS_RESET = 5'd8;

	localparam logic REG_POLY   = 1'b0;
	localparam logic REG_SHIFTS = 1'b1;

	typedef struct packed {
		logic [CRC_W-1:0]   poly;
		logic [SHIFT_W-1:0] shifts;
	} crcr_cfg_t;

endpackage

// ----- rtl/reflected_crc16_configurable.sv -----
// Reflected CRC-16 over a byte stream, configurable polynomial and shift count.
// Top level: APB register block, input register, fold chain, result register.
// Depends on crcr_pkg and crcr_fold.
//
// One byte word is taken every cycle. The exception is a last byte that waits in the
// input register behind a result the receiver is stalling; the input stalls until that
// result is taken. A byte waits in the input register while the sixteen-step
// fold chain updates the accumulator. A last byte then loads the CRC into the result
// register, which drives crc_value. The accumulator clears after each result.
// Registers: polynomial at 0x0 (reset 0xA001), shifts_per_byte at 0x4 (reset 8,
// values above 16 act as 16). Write configuration only while idle.
module reflected_crc16_configurable (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [crcr_pkg::ADDR_W-1:0]   paddr,
	input  logic [crcr_pkg::DATA_W-1:0]   pwdata,
	output logic [crcr_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [crcr_pkg::BYTE_W-1:0]   data_byte,
	input  logic                          last_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [crcr_pkg::CRC_W-1:0]    crc_value
);

	crcr_pkg::crcr_cfg_t cfg_q;
	logic                         cfg_wr;

	logic                         valid_s1;
	logic [crcr_pkg::BYTE_W-1:0]  byte_s1;
	logic                         last_s1;
	logic [crcr_pkg::CRC_W-1:0]   acc_q;
	logic [crcr_pkg::CRC_W-1:0]   acc_next;
	logic                         out_valid_q;
	logic [crcr_pkg::CRC_W-1:0]   crc_q;
	logic                         out_free;
	logic                         go_s1;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poly   <= crcr_pkg::POLY_RESET;
			cfg_q.shifts <= crcr_pkg::SHIFTS_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				crcr_pkg::REG_POLY:   cfg_q.poly   <= pwdata[crcr_pkg::CRC_W-1:0];
				crcr_pkg::REG_SHIFTS: cfg_q.shifts <= pwdata[crcr_pkg::SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			crcr_pkg::REG_POLY:
				prdata = {{(crcr_pkg::DATA_W-crcr_pkg::CRC_W){1'b0}}, cfg_q.poly};
			crcr_pkg::REG_SHIFTS:
				prdata = {{(crcr_pkg::DATA_W-crcr_pkg::SHIFT_W){1'b0}}, cfg_q.shifts};
			default: prdata = '0;
		endcase
	end

	assign out_free = !out_valid_q || !out_stall;
	assign go_s1    = valid_s1 && (!last_s1 || out_free);
	assign in_stall = valid_s1 && !go_s1;

	crcr_fold u_fold (
		.crc_in  (acc_q),
		.data_in (byte_s1),
		.cfg     (cfg_q),
		.crc_out (acc_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (go_s1) begin
			acc_q <= last_s1 ? '0 : acc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			crc_q <= acc_next;
		end
	end

	assign out_valid = out_valid_q;
	assign crc_value = crc_q;

`ifndef SYNTHESIS
	a_last_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		go_s1 && last_s1 |=> out_valid_q && crc_q == $past(acc_next))
		else $error("last byte did not load the result register");

	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		go_s1 && last_s1 |=> acc_q == '0)
		else $error("accumulator not cleared after a result");

	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && last_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked result");

	a_zero_shift_fold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && cfg_q.shifts == '0 |->
			acc_next == (acc_q ^ {{(crcr_pkg::CRC_W-crcr_pkg::BYTE_W){1'b0}}, byte_s1}))
		else $error("zero shift count must only fold the byte in");
`endif

endmodule

// ----- rtl/crcr_fold.sv -----
// Folds one byte into the CRC accumulator: XOR into the low bits, then a
// chain of shift and conditional polynomial XOR steps.
// Depends on crcr_pkg.
module crcr_fold (
	input  logic [crcr_pkg::CRC_W-1:0]  crc_in,
	input  logic [crcr_pkg::BYTE_W-1:0] data_in,
	input  crcr_pkg::crcr_cfg_t         cfg,
	output logic [crcr_pkg::CRC_W-1:0]  crc_out
);

	logic [crcr_pkg::CRC_W-1:0] chain [0:crcr_pkg::MaxShifts];

	assign chain[0] = crc_in ^ {{(crcr_pkg::CRC_W-crcr_pkg::BYTE_W){1'b0}}, data_in};

	for (genvar i = 0; i < crcr_pkg::MaxShifts; i++) begin : g_step
		logic                       en;
		logic [crcr_pkg::CRC_W-1:0] shifted;

		// steps past the configured count pass through, saturating at the chain length
		assign en      = cfg.shifts > crcr_pkg::SHIFT_W'(i);
		assign shifted = {1'b0, chain[i][crcr_pkg::CRC_W-1:1]}
			^ (chain[i][0] ? cfg.poly : '0);
		assign chain[i+1] = en ? shifted : chain[i];
	end

	assign crc_out = chain[crcr_pkg::MaxShifts];

endmodule

// ----- tb/crcr_checker.sv -----
// Checker for the reflected CRC-16 block: watches the APB writes and both word channels.
// Predicts each frame's CRC, compares it with crc_value and counts mismatches.
// Depends on crcr_pkg.
module crcr_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic                          pready,
	input  logic [crcr_pkg::ADDR_W-1:0]   paddr,
	input  logic [crcr_pkg::DATA_W-1:0]   pwdata,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [crcr_pkg::BYTE_W-1:0]   data_byte,
	input  logic                          last_byte,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [crcr_pkg::CRC_W-1:0]    crc_value,
	output int                            fail_count,
	output int                            crc_outstanding,
	output int                            crc_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [crcr_pkg::ADDR_W-1:0] POLY_ADDR   = {crcr_pkg::REG_POLY, 2'b00};
	localparam logic [crcr_pkg::ADDR_W-1:0] SHIFTS_ADDR = {crcr_pkg::REG_SHIFTS, 2'b00};

	logic [crcr_pkg::CRC_W-1:0]   poly_cfg;
	logic [crcr_pkg::SHIFT_W-1:0] shifts_cfg;
	logic [crcr_pkg::CRC_W-1:0]   crc_running;
	logic [crcr_pkg::CRC_W-1:0]   crc_expected_q[$];

	function automatic logic [crcr_pkg::CRC_W-1:0] crc_after_byte(
			input logic [crcr_pkg::CRC_W-1:0] crc,
			input logic [crcr_pkg::BYTE_W-1:0] b, input logic [crcr_pkg::CRC_W-1:0] poly,
			input logic [crcr_pkg::SHIFT_W-1:0] shifts);
		int   steps;
		logic dropped;
		steps = (int'(shifts) > crcr_pkg::MaxShifts) ? crcr_pkg::MaxShifts : int'(shifts);
		crc = crc ^ crcr_pkg::CRC_W'(b);
		for (int i = 0; i < steps; i++) begin
			dropped = crc[0];
			crc = crc >> 1;
			if (dropped) begin
				crc = crc ^ poly;
			end
		end
		return crc;
	endfunction

	initial begin
		fail_count = 0;
		crc_checked = 0;
		crc_outstanding = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		logic [crcr_pkg::CRC_W-1:0] want;
		if (!arst_n) begin
			poly_cfg = crcr_pkg::POLY_RESET;
			shifts_cfg = crcr_pkg::SHIFTS_RESET;
			crc_running = '0;
			crc_expected_q.delete();
			crc_outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == POLY_ADDR) begin
					poly_cfg = pwdata[crcr_pkg::CRC_W-1:0];
				end else if (paddr == SHIFTS_ADDR) begin
					shifts_cfg = pwdata[crcr_pkg::SHIFT_W-1:0];
				end
			end
			if (in_valid && !in_stall) begin
				crc_running = crc_after_byte(crc_running, data_byte, poly_cfg, shifts_cfg);
				if (last_byte) begin
					crc_expected_q.push_back(crc_running);
					crc_running = '0;
				end
			end
			if (out_valid && !out_stall) begin
				if (crc_expected_q.size() == 0) begin
					$display("%0t: unexpected crc_value word: expected none, got %h",
						$time, crc_value);
					fail_count++;
				end else begin
					want = crc_expected_q.pop_front();
					crc_checked++;
					if (crc_value !== want) begin
						$display("%0t: crc_value mismatch: expected %h, got %h",
							$time, want, crc_value);
						fail_count++;
					end
				end
			end
			crc_outstanding <= crc_expected_q.size();
		end
	end

endmodule

// ----- tb/tb_reflected_crc16_configurable.sv -----
// Testbench top for reflected_crc16_configurable: clock, reset, APB writes and byte frames.
// Directed frames, then random frames under changing registers and idling modes.
// Depends on crcr_pkg, crcr_checker and the block itself.
module tb_reflected_crc16_configurable;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	localparam logic [crcr_pkg::ADDR_W-1:0] POLY_ADDR   = {crcr_pkg::REG_POLY, 2'b00};
	localparam logic [crcr_pkg::ADDR_W-1:0] SHIFTS_ADDR = {crcr_pkg::REG_SHIFTS, 2'b00};
	localparam int GROUPS = 12;
	localparam int GROUP_BYTES = 125;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [crcr_pkg::ADDR_W-1:0]   paddr = '0;
	logic [crcr_pkg::DATA_W-1:0]   pwdata = '0;
	logic [crcr_pkg::DATA_W-1:0]   prdata;
	logic                          pready;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [crcr_pkg::BYTE_W-1:0]   data_byte = '0;
	logic                          last_byte = 1'b0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [crcr_pkg::CRC_W-1:0]    crc_value;

	int fail_count;
	int crc_outstanding;
	int crc_checked;
	int sender_idle_pct = 0;
	int rx_stall_pct = 0;
	int bytes_sent = 0;
	int frames_sent = 0;
	int reg_writes = 0;

	always #2 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= (rx_stall_pct != 0) && ($urandom_range(0, 99) < rx_stall_pct);
	end

	reflected_crc16_configurable dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .last_byte(last_byte),
		.out_valid(out_valid), .out_stall(out_stall), .crc_value(crc_value)
	);

	crcr_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .last_byte(last_byte),
		.out_valid(out_valid), .out_stall(out_stall), .crc_value(crc_value),
		.fail_count(fail_count), .crc_outstanding(crc_outstanding),
		.crc_checked(crc_checked)
	);

	task automatic send_byte(input logic [crcr_pkg::BYTE_W-1:0] b, input logic last);
		while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		bytes_sent++;
		if (last) begin
			frames_sent++;
		end
	endtask

	// hold off until every CRC word is out and the pipeline has emptied
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (crc_outstanding != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [crcr_pkg::ADDR_W-1:0] addr,
			input logic [crcr_pkg::DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		reg_writes++;
	endtask

	task automatic set_config(input logic [crcr_pkg::CRC_W-1:0] poly,
			input logic [crcr_pkg::SHIFT_W-1:0] shifts);
		drain();
		write_reg(POLY_ADDR, {16'($urandom()), poly});
		write_reg(SHIFTS_ADDR, {27'($urandom()), shifts});
	endtask

	task automatic set_idle_mode(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				sender_idle_pct = 0;
				rx_stall_pct <= 0;
			end
			IDLE_SENDER: begin
				sender_idle_pct = 71;
				rx_stall_pct <= 0;
			end
			IDLE_RECEIVER: begin
				sender_idle_pct = 0;
				rx_stall_pct <= 71;
			end
			default: begin
				sender_idle_pct = 10;
				rx_stall_pct <= 10;
			end
		endcase
	endtask

	initial begin
		int                           frame_left;
		logic [crcr_pkg::CRC_W-1:0]   poly;
		logic [crcr_pkg::SHIFT_W-1:0] shifts;
		frame_left = 0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h12, 1'b0);
		send_byte(8'h34, 1'b0);
		send_byte(8'hAB, 1'b1);
		// change shift count to zero inside an open frame
		send_byte(8'h5A, 1'b0);
		set_config(crcr_pkg::POLY_RESET, 5'd0);
		send_byte(8'hA5, 1'b1);
		// shift count above the chain length saturates
		set_config(16'hFFFF, 5'd31);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h01, 1'b1);
		set_config(16'h0000, 5'd16);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b1);
		set_config(16'h8408, 5'd17);
		send_byte(8'h55, 1'b1);

		for (int g = 0; g < GROUPS; g++) begin
			case ($urandom_range(0, 4))
				0: poly = crcr_pkg::POLY_RESET;
				1: poly = 16'h8408;
				2: poly = 16'h0000;
				3: poly = 16'hFFFF;
				default: poly = 16'($urandom());
			endcase
			case ($urandom_range(0, 4))
				0: shifts = 5'd8;
				1: shifts = 5'd16;
				2: shifts = (g % 2 == 0) ? 5'd0 : 5'd31;
				default: shifts = 5'($urandom_range(0, 31));
			endcase
			set_config(poly, shifts);
			set_idle_mode(idle_mode_t'(g % 4));
			for (int k = 0; k < GROUP_BYTES; k++) begin
				if (frame_left == 0) begin
					frame_left = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 16);
				end
				frame_left--;
				send_byte(8'($urandom_range(0, 255)), frame_left == 0);
			end
		end

		drain();
		$display("Sent %0d bytes in %0d frames; %0d CRC words checked after %0d register writes.",
			bytes_sent, frames_sent, crc_checked, reg_writes);
		$display("Shift counts from 0 to 31, extreme polynomials and all four idling modes used.");
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("Timed out with %0d CRC words outstanding.", crc_outstanding);
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/crcr_pkg.sv
rtl/crcr_fold.sv
rtl/reflected_crc16_configurable.sv
tb/crcr_checker.sv
tb/tb_reflected_crc16_configurable.sv
